@@ rtl/ccep_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccep_pkg: shared types and constants of the cluster chain extent packer
// Field widths, the end-of-chain mark, parameter defaults and the item types
// that pass between the front end, the command queue and the back end.
// ----------------------------------------------------------------------------
package ccep_pkg;

  // Widths of the input and result fields.
  localparam int CLUSTER_W    = 12;
  localparam int RUN_LEN_W    = 4;
  localparam int SLOT_W       = 3;
  localparam int FRAGMENT_W   = 9;
  localparam int FILL_W       = 4;

  // Width used to work out fragment wrap for any fragment count up to 4096.
  localparam int FRAG_CALC_W  = 13;

  // A FAT12 value at or above this mark ends the chain.
  localparam logic [CLUSTER_W-1:0] END_MARK     = 12'hFF8;
  localparam logic [CLUSTER_W-1:0] LAST_CLUSTER = 12'hFFF;

  // Parameter defaults.
  localparam int DEF_CLUSTERS_PER_FRAGMENT = 8;
  localparam int DEF_MAX_FRAGMENTS         = 512;

  // Depth of the queue between front and back end.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = 1;
  localparam int QUEUE_CNT_W = 2;

  // One input item.
  typedef struct packed {
    logic [CLUSTER_W-1:0] cluster;
    logic                 first;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [CLUSTER_W-1:0]  run_start;
    logic [RUN_LEN_W-1:0]  run_length;
    logic [SLOT_W-1:0]     slot;
    logic [FRAGMENT_W-1:0] fragment;
    logic                  last_run;
  } out_item_t;

  // Classification made by the front end.
  typedef enum logic [1:0] {
    KIND_START,
    KIND_START_EMPTY,
    KIND_VALUE,
    KIND_END
  } cmd_kind_t;

  // Command handed from front end to back end.
  typedef struct packed {
    cmd_kind_t            kind;
    logic [CLUSTER_W-1:0] cluster;
  } cmd_t;

  // Push and pop handshakes around the command queue.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_push_t;

endpackage

@@ rtl/ccep_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccep_in_if / ccep_out_if: valid-ready channels of the extent packer
// The input channel carries FAT chain items, the output channel carries
// finished runs. An item moves at a clock edge where valid and ready are high.
// ----------------------------------------------------------------------------
interface ccep_in_if;
  logic               valid;
  logic               ready;
  ccep_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ccep_out_if;
  logic                valid;
  logic                ready;
  ccep_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/cluster_chain_extent_packer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cluster_chain_extent_packer_core: FAT12 cluster chain to extent packer
// Packs a FAT12 cluster chain into runs of consecutive clusters, cut at
// fragment boundaries, and emits each run with its slot and fragment number.
// ----------------------------------------------------------------------------
// The block takes one chain item per clock cycle and keeps that rate as long
// as results are taken. The item that closes a run waits in the two-entry
// command queue behind the classifying front end; its run is then registered
// in the back end, which updates the run state for one command per cycle
// while its result register is empty or being emptied. Items that close no run
// (chain starts, consecutive clusters, values outside a chain) give no result.
// ----------------------------------------------------------------------------
module cluster_chain_extent_packer_core #(
  parameter int CLUSTERS_PER_FRAGMENT = ccep_pkg::DEF_CLUSTERS_PER_FRAGMENT,
  parameter int MAX_FRAGMENTS         = ccep_pkg::DEF_MAX_FRAGMENTS
) (
  input logic        clk,
  input logic        rst,
  ccep_in_if.sink    entry,
  ccep_out_if.source run
);

  ccep_pkg::cmd_push_t push;
  ccep_pkg::cmd_push_t pop;
  logic                push_ready;
  logic                pop_ready;

  // Front end: accept and classify.
  ccep_front u_front (
    .entry      (entry),
    .push       (push),
    .push_ready (push_ready)
  );

  // Command queue.
  ccep_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_ready  (pop_ready)
  );

  // Back end: run tracking and results.
  ccep_back #(
    .CLUSTERS_PER_FRAGMENT (CLUSTERS_PER_FRAGMENT),
    .MAX_FRAGMENTS         (MAX_FRAGMENTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop       (pop),
    .pop_ready (pop_ready),
    .run       (run)
  );

endmodule

@@ rtl/ccep_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccep_front: input acceptance and classification
// Accepts chain items whenever the command queue has room and sorts each into
// chain start, empty chain, chain value or end of chain.
// ----------------------------------------------------------------------------
module ccep_front (
  ccep_in_if.sink          entry,
  output ccep_pkg::cmd_push_t push,
  input  logic             push_ready
);

  logic is_end;

  // An item is taken whenever the queue can hold it.
  assign entry.ready = push_ready;

  assign is_end = (entry.data.cluster >= ccep_pkg::END_MARK);

  // Classify the item by its first flag and the end-of-chain mark.
  always_comb begin
    push.valid       = entry.valid;
    push.cmd.cluster = entry.data.cluster;
    if (entry.data.first) begin
      push.cmd.kind = is_end ? ccep_pkg::KIND_START_EMPTY : ccep_pkg::KIND_START;
    end else begin
      push.cmd.kind = is_end ? ccep_pkg::KIND_END : ccep_pkg::KIND_VALUE;
    end
  end

endmodule

@@ rtl/ccep_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccep_queue: short command queue between front and back end
// A two-entry FIFO of classified commands so that each side may stall alone.
// ----------------------------------------------------------------------------
module ccep_queue (
  input  logic                clk,
  input  logic                rst,
  input  ccep_pkg::cmd_push_t push,
  output logic                push_ready,
  output ccep_pkg::cmd_push_t pop,
  input  logic                pop_ready
);

  ccep_pkg::cmd_t                       store [ccep_pkg::QUEUE_DEPTH];
  logic [ccep_pkg::QUEUE_PTR_W-1:0]     wr_ptr;
  logic [ccep_pkg::QUEUE_PTR_W-1:0]     rd_ptr;
  logic [ccep_pkg::QUEUE_CNT_W-1:0]     count;
  logic                                 do_push;
  logic                                 do_pop;

  assign push_ready = (count != ccep_pkg::QUEUE_CNT_W'(ccep_pkg::QUEUE_DEPTH));
  assign pop.valid  = (count != '0);
  assign pop.cmd    = store[rd_ptr];

  assign do_push = push.valid && push_ready;
  assign do_pop  = pop.valid && pop_ready;

  // Storage write.
  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push.cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/ccep_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccep_back: run tracking and result register
// Holds the chain state, merges consecutive clusters into runs, closes runs at
// gaps, on fragment boundaries and at the end of the chain, and registers each result.
// ----------------------------------------------------------------------------
module ccep_back #(
  parameter int CLUSTERS_PER_FRAGMENT = ccep_pkg::DEF_CLUSTERS_PER_FRAGMENT,
  parameter int MAX_FRAGMENTS         = ccep_pkg::DEF_MAX_FRAGMENTS
) (
  input  logic                clk,
  input  logic                rst,
  input  ccep_pkg::cmd_push_t pop,
  output logic                pop_ready,
  ccep_out_if.source          run
);

  localparam int FragW = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;

  // Chain state.
  logic [ccep_pkg::CLUSTER_W-1:0] prev_cluster, prev_cluster_next;
  logic [ccep_pkg::RUN_LEN_W-1:0] run_count, run_count_next;
  logic [ccep_pkg::SLOT_W-1:0]    slot_index, slot_index_next;
  logic [ccep_pkg::FILL_W-1:0]    clusters_in_fragment, clusters_in_fragment_next;
  logic [FragW-1:0]               fragment_index, fragment_index_next;
  logic                           chain_active, chain_active_next;

  // Result register.
  logic                           out_valid, out_valid_next;
  ccep_pkg::out_item_t            out_data;

  logic                           take;
  logic                           emit;
  logic                           emit_last;
  logic                           consecutive;
  logic                           fragment_full;
  logic [ccep_pkg::CLUSTER_W-1:0] cur_cluster;
  logic [ccep_pkg::FRAG_CALC_W-1:0] frag_ext;
  logic [ccep_pkg::FRAG_CALC_W-1:0] frag_inc;
  ccep_pkg::out_item_t            result;

  assign run.valid = out_valid;
  assign run.data  = out_data;

  // A command is taken when the result register is free or being emptied.
  assign pop_ready = !out_valid || run.ready;
  assign take      = pop.valid && pop_ready;

  assign cur_cluster   = pop.cmd.cluster;
  assign consecutive   = (prev_cluster != ccep_pkg::LAST_CLUSTER) &&
                         (cur_cluster == prev_cluster + 1'b1);
  assign fragment_full = (clusters_in_fragment >=
                          ccep_pkg::FILL_W'(CLUSTERS_PER_FRAGMENT));
  assign frag_ext      = ccep_pkg::FRAG_CALC_W'(fragment_index);
  assign frag_inc      = frag_ext + 1'b1;

  // The open run as a result item.
  always_comb begin
    result.run_start  = prev_cluster - ccep_pkg::CLUSTER_W'(run_count) + 1'b1;
    result.run_length = run_count;
    result.slot       = slot_index;
    result.fragment   = frag_ext[ccep_pkg::FRAGMENT_W-1:0];
    result.last_run   = emit_last;
  end

  // Next chain state for the command being taken.
  always_comb begin
    prev_cluster_next         = prev_cluster;
    run_count_next            = run_count;
    slot_index_next           = slot_index;
    clusters_in_fragment_next = clusters_in_fragment;
    fragment_index_next       = fragment_index;
    chain_active_next         = chain_active;
    emit                      = 1'b0;
    emit_last                 = 1'b0;
    if (take) begin
      unique case (pop.cmd.kind)
        ccep_pkg::KIND_START: begin
          prev_cluster_next         = cur_cluster;
          run_count_next            = ccep_pkg::RUN_LEN_W'(1);
          slot_index_next           = '0;
          clusters_in_fragment_next = ccep_pkg::FILL_W'(1);
          fragment_index_next       = '0;
          chain_active_next         = 1'b1;
        end
        ccep_pkg::KIND_START_EMPTY: begin
          prev_cluster_next         = '0;
          run_count_next            = '0;
          slot_index_next           = '0;
          clusters_in_fragment_next = '0;
          fragment_index_next       = '0;
          chain_active_next         = 1'b0;
        end
        ccep_pkg::KIND_END: begin
          if (chain_active) begin
            emit                      = 1'b1;
            emit_last                 = 1'b1;
            prev_cluster_next         = '0;
            run_count_next            = '0;
            slot_index_next           = '0;
            clusters_in_fragment_next = '0;
            fragment_index_next       = '0;
            chain_active_next         = 1'b0;
          end
        end
        ccep_pkg::KIND_VALUE: begin
          if (chain_active) begin
            if (fragment_full) begin
              // Fragment full: close the run and move to the next fragment.
              emit                      = 1'b1;
              slot_index_next           = '0;
              clusters_in_fragment_next = ccep_pkg::FILL_W'(1);
              prev_cluster_next         = cur_cluster;
              run_count_next            = ccep_pkg::RUN_LEN_W'(1);
              if (frag_inc >= ccep_pkg::FRAG_CALC_W'(MAX_FRAGMENTS)) begin
                fragment_index_next = '0;
              end else begin
                fragment_index_next = FragW'(frag_inc);
              end
            end else begin
              clusters_in_fragment_next = clusters_in_fragment + 1'b1;
              prev_cluster_next         = cur_cluster;
              if (consecutive) begin
                run_count_next = run_count + 1'b1;
              end else begin
                // Gap in the chain: close the run and open a new one.
                emit            = 1'b1;
                slot_index_next = slot_index + 1'b1;
                run_count_next  = ccep_pkg::RUN_LEN_W'(1);
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
    out_valid_next = emit ? 1'b1 : (run.ready ? 1'b0 : out_valid);
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_cluster         <= '0;
      run_count            <= '0;
      slot_index           <= '0;
      clusters_in_fragment <= '0;
      fragment_index       <= '0;
      chain_active         <= 1'b0;
      out_valid            <= 1'b0;
    end else begin
      prev_cluster         <= prev_cluster_next;
      run_count            <= run_count_next;
      slot_index           <= slot_index_next;
      clusters_in_fragment <= clusters_in_fragment_next;
      fragment_index       <= fragment_index_next;
      chain_active         <= chain_active_next;
      out_valid            <= out_valid_next;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= result;
    end
  end

endmodule

@@ tb/cluster_chain_extent_packer_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cluster_chain_extent_packer_core_test: self-checking bench of the packer
// Feeds FAT12 chain items through the entry channel and tracks the run state
// in a local predictor. Every run taken from the run channel is compared field
// by field with the oldest predicted run. Directed chains come first, then a
// chain that runs through many fragments, a long result stall, and finally
// random chains mixed with noise. Both sides idle at random.
// ----------------------------------------------------------------------------
module cluster_chain_extent_packer_core_test;

  localparam int CPF            = ccep_pkg::DEF_CLUSTERS_PER_FRAGMENT;
  localparam int MAXF           = ccep_pkg::DEF_MAX_FRAGMENTS;
  localparam int LONG_FRAGMENTS = 24;
  localparam int RANDOM_ITEMS   = 1200;
  localparam int HOLD_CYCLES    = 120;
  localparam int STALL_LIMIT    = 2000;
  localparam logic [ccep_pkg::CLUSTER_W-1:0] TOP_CLUSTER = ccep_pkg::END_MARK - 1'b1;

  logic clk = 1'b0;
  logic rst;

  ccep_in_if  entry_if ();
  ccep_out_if run_if ();

  cluster_chain_extent_packer_core #(
    .CLUSTERS_PER_FRAGMENT(CPF),
    .MAX_FRAGMENTS(MAXF)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .entry(entry_if.sink),
    .run(run_if.source)
  );

  always #5 clk = ~clk;

  // Predicted walk state of the chain.
  logic [ccep_pkg::CLUSTER_W-1:0]  walk_prev   = '0;
  logic [ccep_pkg::RUN_LEN_W-1:0]  walk_len    = '0;
  logic [ccep_pkg::SLOT_W-1:0]     walk_slot   = '0;
  logic [ccep_pkg::FILL_W-1:0]     walk_fill   = '0;
  logic [ccep_pkg::FRAGMENT_W-1:0] walk_frag   = '0;
  bit                              walk_active = 1'b0;

  ccep_pkg::out_item_t pending_runs[$];
  int unsigned fail_count    = 0;
  int unsigned chain_items   = 0;
  int unsigned burst_left    = 0;
  int unsigned hold_asked    = 0;
  int unsigned idle_cycles   = 0;

  function automatic void clear_walk();
    walk_prev   = '0;
    walk_len    = '0;
    walk_slot   = '0;
    walk_fill   = '0;
    walk_frag   = '0;
    walk_active = 1'b0;
  endfunction

  // The open run as it would leave the block.
  function automatic ccep_pkg::out_item_t closed_run(input logic last);
    ccep_pkg::out_item_t r;
    r.run_start  = walk_prev - ccep_pkg::CLUSTER_W'(walk_len) + 1'b1;
    r.run_length = walk_len;
    r.slot       = walk_slot;
    r.fragment   = walk_frag;
    r.last_run   = last;
    return r;
  endfunction

  // Advances the walk by one chain item; returns 1 when a run is closed.
  function automatic bit pack_entry(input logic [ccep_pkg::CLUSTER_W-1:0] c,
                                    input logic f,
                                    output ccep_pkg::out_item_t r);
    r = '0;
    if (f) begin
      clear_walk();
      if (c >= ccep_pkg::END_MARK) return 1'b0;
      walk_prev   = c;
      walk_len    = ccep_pkg::RUN_LEN_W'(1);
      walk_fill   = ccep_pkg::FILL_W'(1);
      walk_active = 1'b1;
      return 1'b0;
    end
    if (!walk_active) return 1'b0;
    if (c >= ccep_pkg::END_MARK) begin
      r = closed_run(1'b1);
      clear_walk();
      return 1'b1;
    end
    // A full fragment closes the run whatever the cluster number.
    if (int'(walk_fill) >= CPF) begin
      r = closed_run(1'b0);
      walk_frag = (int'(walk_frag) + 1 >= MAXF) ? '0 : walk_frag + 1'b1;
      walk_slot = '0;
      walk_fill = ccep_pkg::FILL_W'(1);
      walk_prev = c;
      walk_len  = ccep_pkg::RUN_LEN_W'(1);
      return 1'b1;
    end
    walk_fill = walk_fill + 1'b1;
    if (walk_prev != ccep_pkg::LAST_CLUSTER && c == walk_prev + 1'b1) begin
      walk_prev = c;
      walk_len  = walk_len + 1'b1;
      return 1'b0;
    end
    r = closed_run(1'b0);
    walk_slot = walk_slot + 1'b1;
    walk_prev = c;
    walk_len  = ccep_pkg::RUN_LEN_W'(1);
    return 1'b1;
  endfunction

  // Offers one item in bursts with random gaps and predicts its effect once taken.
  task automatic feed(input logic [ccep_pkg::CLUSTER_W-1:0] c, input logic f);
    int unsigned gap;
    ccep_pkg::out_item_t r;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
      if (gap != 0) begin
        entry_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    entry_if.valid <= 1'b1;
    entry_if.data  <= '{cluster: c, first: f};
    do @(posedge clk); while (!entry_if.ready);
    if (f || walk_active) chain_items++;
    if (pack_entry(c, f, r)) pending_runs.push_back(r);
  endtask

  // Stops offering until every predicted run has been taken.
  task automatic wait_for_runs();
    entry_if.valid <= 1'b0;
    while (pending_runs.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    int unsigned i;
    // Empty chain, then a chain value with no chain open.
    feed(ccep_pkg::END_MARK, 1'b1);
    feed(12'd5, 1'b0);
    // Reserved clusters 0 and 1 form an ordinary run.
    feed(12'd0, 1'b1);
    feed(12'd1, 1'b0);
    feed(12'd2, 1'b0);
    feed(ccep_pkg::LAST_CLUSTER, 1'b0);
    // Highest usable clusters in one run.
    feed(TOP_CLUSTER - 1'b1, 1'b1);
    feed(TOP_CLUSTER, 1'b0);
    feed(12'hFF9, 1'b0);
    // A new chain drops the open run without a result.
    feed(12'd100, 1'b1);
    feed(12'd101, 1'b0);
    feed(12'd7, 1'b1);
    feed(12'd9, 1'b0);
    feed(ccep_pkg::END_MARK, 1'b0);
    // Nine consecutive clusters are cut at the fragment boundary.
    feed(12'd16, 1'b1);
    for (i = 17; i <= 24; i++) feed(ccep_pkg::CLUSTER_W'(i), 1'b0);
    feed(12'hFFC, 1'b0);
    feed(ccep_pkg::LAST_CLUSTER, 1'b0);
    wait_for_runs();
  endtask

  // One chain that runs through many fragments, some of them broken up.
  task automatic test_long_chain();
    logic [ccep_pkg::CLUSTER_W-1:0] c;
    int unsigned frag;
    bit broken;
    c = ccep_pkg::CLUSTER_W'($urandom_range(0, 12'h7FF));
    feed(c, 1'b1);
    for (frag = 0; frag < LONG_FRAGMENTS; frag++) begin
      broken = ($urandom_range(0, 3) == 0);
      repeat (CPF) begin
        if (!broken && c != TOP_CLUSTER) c = c + 1'b1;
        else c = ccep_pkg::CLUSTER_W'($urandom_range(0, TOP_CLUSTER));
        feed(c, 1'b0);
      end
    end
    feed(ccep_pkg::END_MARK, 1'b0);
    wait_for_runs();
  endtask

  // The run side holds off for a long stretch while runs keep being closed.
  task automatic test_result_backpressure();
    hold_asked++;
    feed(ccep_pkg::CLUSTER_W'($urandom_range(0, TOP_CLUSTER)), 1'b1);
    repeat (48) feed(ccep_pkg::CLUSTER_W'($urandom_range(0, TOP_CLUSTER)), 1'b0);
    feed(ccep_pkg::CLUSTER_W'($urandom_range(ccep_pkg::END_MARK, ccep_pkg::LAST_CLUSTER)),
         1'b0);
    wait_for_runs();
  endtask

  // Mostly well-formed chains with random content, the rest noise.
  task automatic test_random_chains();
    logic [ccep_pkg::CLUSTER_W-1:0] c;
    int unsigned goal, len, pick;
    goal = chain_items + RANDOM_ITEMS;
    while (chain_items < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        c = ($urandom_range(0, 9) == 0)
            ? ccep_pkg::CLUSTER_W'($urandom_range(12'hFF0, TOP_CLUSTER))
            : ccep_pkg::CLUSTER_W'($urandom_range(0, TOP_CLUSTER));
        feed(c, 1'b1);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 12);
        repeat (len) begin
          if (c != TOP_CLUSTER && $urandom_range(0, 9) < 7) c = c + 1'b1;
          else c = ccep_pkg::CLUSTER_W'($urandom_range(0, TOP_CLUSTER));
          feed(c, 1'b0);
        end
        // Now and then the chain is abandoned and the next start drops it.
        if ($urandom_range(0, 9) != 0) begin
          feed(ccep_pkg::CLUSTER_W'($urandom_range(ccep_pkg::END_MARK,
                                                   ccep_pkg::LAST_CLUSTER)), 1'b0);
        end
      end else if (pick < 90) begin
        feed(ccep_pkg::CLUSTER_W'($urandom_range(ccep_pkg::END_MARK, ccep_pkg::LAST_CLUSTER)),
             1'b1);
      end else begin
        feed(ccep_pkg::CLUSTER_W'($urandom_range(0, ccep_pkg::LAST_CLUSTER)),
             1'($urandom_range(0, 1)));
      end
    end
    wait_for_runs();
  endtask

  // Run side: stalls in random patterns, each kept over a random span, and holds off when asked.
  initial begin
    int unsigned mode = 0;
    int unsigned span = 0;
    int unsigned tick = 0;
    int unsigned hold_served = 0;
    run_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asked != hold_served) begin
        run_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_served = hold_asked;
        span = 0;
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 3);
          span = $urandom_range(16, 96);
        end
        span--;
        tick++;
        case (mode)
          0: run_if.ready <= 1'b1;
          1: run_if.ready <= 1'($urandom_range(0, 1));
          2: run_if.ready <= ($urandom_range(0, 3) != 0);
          default: run_if.ready <= ((tick % 8) < 5);
        endcase
      end
    end
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Each run taken is compared with the oldest predicted one.
  always @(posedge clk) begin : check_runs
    ccep_pkg::out_item_t want;
    if (!rst && run_if.valid && run_if.ready) begin
      if (pending_runs.size() == 0) begin
        $error("run taken with no run predicted: start %0d", run_if.data.run_start);
        fail_count++;
      end else begin
        want = pending_runs.pop_front();
        check_field("run_start", want.run_start, run_if.data.run_start);
        check_field("run_length", want.run_length, run_if.data.run_length);
        check_field("slot", want.slot, run_if.data.slot);
        check_field("fragment", want.fragment, run_if.data.fragment);
        check_field("last_run", want.last_run, run_if.data.last_run);
      end
    end
  end

  // Ends the run if neither channel moves an item for too long.
  always @(posedge clk) begin
    if ((entry_if.valid && entry_if.ready) || (run_if.valid && run_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    entry_if.valid = 1'b0;
    entry_if.data  = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_long_chain();
    test_result_backpressure();
    test_random_chains();
    wait_for_runs();
    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ cluster_chain_extent_packer_core.f @@
rtl/ccep_pkg.sv
rtl/ccep_if.sv
rtl/ccep_front.sv
rtl/ccep_queue.sv
rtl/ccep_back.sv
rtl/cluster_chain_extent_packer_core.sv
tb/cluster_chain_extent_packer_core_test.sv
